/* rtl/fvnh_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the fractal value noise height block.
// No dependencies; every other file refers to it by scoped names.
package fvnh_pkg;

   // Table and octave sizing
   localparam int TABLE_ENTRIES = 256;
   localparam int MAX_OCTAVES   = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int OCTN_W        = $clog2(MAX_OCTAVES + 1);

   // Datapath widths derived from the octave bound; SPLIT is a fixed choice
   localparam int SUM_W  = 34 + $clog2(MAX_OCTAVES) + 1;  // sum of amp * level
   localparam int S16_W  = SUM_W - 14;                    // sum in Q.16
   localparam int P1_W   = S16_W + 18;                    // times sqrt(2)
   localparam int SPLIT  = 21;                            // low part of P1 split
   localparam int HI_W   = P1_W - SPLIT;
   localparam int NUM_W  = P1_W + 18;                     // full numerator
   localparam int DIV_W  = NUM_W - 17;                    // numerator over 2^17
   localparam int H_W    = DIV_W + 2;
   localparam int STEP_W = $clog2(DIV_W + 1);

   // Last step index of each sequencer state
   localparam int WGT_LAST   = 8;
   localparam int LUT_LAST   = 7;
   localparam int BLEND_LAST = 2;
   localparam int FIN_LAST   = 2;
   localparam int DIV_LAST   = DIV_W - 1;

   // Arithmetic constants
   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [16:0] SQRT2_Q16   = 17'd92682;
   localparam logic [17:0] CURVE_THREE = 18'd196608;
   localparam logic [16:0] HALF_Q16    = 17'd32768;

   // Register reset values
   localparam logic [15:0] RESET_PERSIST = 16'd32768;
   localparam logic [12:0] RESET_LACUN   = 13'd512;
   localparam logic [4:0]  RESET_OCTAVES = 5'd4;

   typedef enum logic [1:0] {
      OP_PERM  = 2'd0,
      OP_LEVEL = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_PERSISTENCE = 2'd0,
      CSR_LACUNARITY  = 2'd1,
      CSR_OCTAVES     = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [7:0]          table_index;
      logic [7:0]          perm_value;
      logic signed [15:0]  level_value;
      logic [31:0]         x_coord;
      logic [31:0]         z_coord;
   } req_type;

   typedef struct packed {
      logic [15:0] height;
      logic        clipped;
   } rsp_type;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_WRITE,
      CMD_LOAD,
      CMD_WGT,
      CMD_LUT,
      CMD_BLEND,
      CMD_ACC,
      CMD_FIN,
      CMD_DIV,
      CMD_OUT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [STEP_W-1:0]  step;
   } cmd_type;

   typedef struct packed {
      logic [OCTN_W-1:0] oct_n;
      logic              out_free;
   } status_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WGT   = 8'b0000_0010,
      ST_LUT   = 8'b0000_0100,
      ST_BLEND = 8'b0000_1000,
      ST_ACC   = 8'b0001_0000,
      ST_FIN   = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   function automatic logic [IDX_W-1:0] to_idx(input logic [15:0] v);
      return v[IDX_W-1:0];
   endfunction

endpackage

/* rtl/fvnh_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the noise block: issues table writes and, per query, walks weights,
// lookups, blends, accumulate, final scaling, the divider and the output handoff. Uses fvnh_pkg.
module fvnh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fvnh_pkg::opcode_type  req_opcode,
   input  fvnh_pkg::status_type  status,
   output fvnh_pkg::cmd_type     cmd
);

   fvnh_pkg::state_type               state_ff, state_in;
   logic [fvnh_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [fvnh_pkg::OCTN_W-1:0]       oct_ff, oct_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      oct_in    = oct_ff;
      req_ready = 1'b0;
      cmd.op    = fvnh_pkg::CMD_IDLE;
      cmd.step  = step_ff;
      unique case (state_ff)
         fvnh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == fvnh_pkg::OP_QUERY) begin
                  cmd.op   = fvnh_pkg::CMD_LOAD;
                  state_in = fvnh_pkg::ST_WGT;
                  step_in  = '0;
                  oct_in   = '0;
               end else begin
                  cmd.op = fvnh_pkg::CMD_WRITE;
               end
            end
         end
         fvnh_pkg::ST_WGT: begin
            cmd.op = fvnh_pkg::CMD_WGT;
            if (step_ff == fvnh_pkg::STEP_W'(fvnh_pkg::WGT_LAST)) begin
               state_in = fvnh_pkg::ST_LUT;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fvnh_pkg::ST_LUT: begin
            cmd.op = fvnh_pkg::CMD_LUT;
            if (step_ff == fvnh_pkg::STEP_W'(fvnh_pkg::LUT_LAST)) begin
               state_in = fvnh_pkg::ST_BLEND;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fvnh_pkg::ST_BLEND: begin
            cmd.op = fvnh_pkg::CMD_BLEND;
            if (step_ff == fvnh_pkg::STEP_W'(fvnh_pkg::BLEND_LAST)) begin
               state_in = fvnh_pkg::ST_ACC;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fvnh_pkg::ST_ACC: begin
            cmd.op  = fvnh_pkg::CMD_ACC;
            step_in = '0;
            if (oct_ff == status.oct_n - 1'b1) begin
               state_in = fvnh_pkg::ST_FIN;
            end else begin
               oct_in   = oct_ff + 1'b1;
               state_in = fvnh_pkg::ST_WGT;
            end
         end
         fvnh_pkg::ST_FIN: begin
            cmd.op = fvnh_pkg::CMD_FIN;
            if (step_ff == fvnh_pkg::STEP_W'(fvnh_pkg::FIN_LAST)) begin
               state_in = fvnh_pkg::ST_DIV;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fvnh_pkg::ST_DIV: begin
            cmd.op = fvnh_pkg::CMD_DIV;
            if (step_ff == fvnh_pkg::STEP_W'(fvnh_pkg::DIV_LAST)) begin
               state_in = fvnh_pkg::ST_DONE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fvnh_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.op   = fvnh_pkg::CMD_OUT;
               state_in = fvnh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fvnh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fvnh_pkg::ST_IDLE;
         step_ff  <= '0;
         oct_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         oct_ff   <= oct_in;
      end
   end

endmodule

/* rtl/fvnh_datapath.sv */
`timescale 1ns / 1ps
// Datapath: config registers, permutation and level memories, curve multiplier,
// blend unit, accumulator, final scaling, divider and result register. Uses fvnh_pkg.
module fvnh_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  fvnh_pkg::cmd_type     cmd,
   output fvnh_pkg::status_type  status,
   input  fvnh_pkg::req_type     req_data,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fvnh_pkg::rsp_type     rsp_data
);

   localparam int IW  = fvnh_pkg::IDX_W;
   localparam int SW  = fvnh_pkg::SUM_W;
   localparam int P1W = fvnh_pkg::P1_W;
   localparam int HW  = fvnh_pkg::HI_W;
   localparam int NW  = fvnh_pkg::NUM_W;
   localparam int DW  = fvnh_pkg::DIV_W;
   localparam int SP  = fvnh_pkg::SPLIT;

   // Configuration
   logic [15:0] persist_ff;
   logic [12:0] lacun_ff;
   logic [4:0]  octs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         persist_ff <= fvnh_pkg::RESET_PERSIST;
         lacun_ff   <= fvnh_pkg::RESET_LACUN;
         octs_ff    <= fvnh_pkg::RESET_OCTAVES;
      end else if (csr_valid) begin
         unique case (fvnh_pkg::csr_index_type'(csr_index))
            fvnh_pkg::CSR_PERSISTENCE: persist_ff <= csr_data;
            fvnh_pkg::CSR_LACUNARITY:  lacun_ff   <= csr_data[12:0];
            fvnh_pkg::CSR_OCTAVES:     octs_ff    <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Octave count clamped to 1..MAX_OCTAVES
   always_comb begin
      priority if (octs_ff == '0)
         status.oct_n = fvnh_pkg::OCTN_W'(1);
      else if (32'(octs_ff) > fvnh_pkg::MAX_OCTAVES)
         status.oct_n = fvnh_pkg::OCTN_W'(fvnh_pkg::MAX_OCTAVES);
      else
         status.oct_n = fvnh_pkg::OCTN_W'(octs_ff);
   end

   // Query state
   logic [31:0] x_ff, z_ff;
   logic [15:0] g_ff, t_ff, wx_ff, wz_ff;

   // Curve multiplier: squares on odd steps, cubic term on even steps
   logic [15:0] cm_a;
   logic [17:0] cm_b;
   logic [33:0] cm_p;

   always_comb begin
      if (cmd.step[0]) begin
         cm_a = g_ff;
         cm_b = {2'b00, g_ff};
      end else begin
         cm_a = t_ff;
         cm_b = fvnh_pkg::CURVE_THREE - {1'b0, g_ff, 1'b0};
      end
      cm_p = cm_a * cm_b;
   end

   // Table memories, one read port each, registered read data
   logic [7:0]          perm_mem [fvnh_pkg::TABLE_ENTRIES];
   logic [15:0]         level_mem [fvnh_pkg::TABLE_ENTRIES];
   logic [IW-1:0]       perm_addr, level_addr, wr_addr;
   logic [7:0]          perm_rd_ff;
   logic signed [15:0]  level_rd_ff;
   logic [IW-1:0]       i_ff, j_ff, dx, dz;
   logic signed [15:0]  a0_ff, b0_ff, a1_ff, b1_ff;

   assign dx      = fvnh_pkg::to_idx(x_ff[31:16]);
   assign dz      = fvnh_pkg::to_idx(z_ff[31:16]);
   assign wr_addr = fvnh_pkg::to_idx({8'h00, req_data.table_index});
   assign level_addr = fvnh_pkg::to_idx({8'h00, perm_rd_ff});

   always_comb begin
      unique case (cmd.step[2:0])
         3'd0:    perm_addr = dx;
         3'd1:    perm_addr = dx + 1'b1;
         3'd2:    perm_addr = i_ff + dz;
         3'd3:    perm_addr = j_ff + dz;
         3'd4:    perm_addr = i_ff + dz + 1'b1;
         default: perm_addr = j_ff + dz + 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == fvnh_pkg::CMD_WRITE && req_data.opcode == fvnh_pkg::OP_PERM)
         perm_mem[wr_addr] <= req_data.perm_value;
      perm_rd_ff <= perm_mem[perm_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == fvnh_pkg::CMD_WRITE && req_data.opcode == fvnh_pkg::OP_LEVEL)
         level_mem[wr_addr] <= req_data.level_value;
      level_rd_ff <= level_mem[level_addr];
   end

   // Blend unit: a + floor(w * (b - a) / 2^16)
   logic signed [15:0] bl_a, bl_b, bl_res;
   logic [15:0]        bl_w;
   logic signed [16:0] bl_diff;
   logic signed [33:0] bl_prod;
   logic signed [17:0] bl_sum;
   logic signed [15:0] v0_ff, v1_ff, noise_ff;

   always_comb begin
      unique case (cmd.step[1:0])
         2'd0: begin
            bl_a = a0_ff; bl_b = b0_ff; bl_w = wx_ff;
         end
         2'd1: begin
            bl_a = a1_ff; bl_b = b1_ff; bl_w = wx_ff;
         end
         default: begin
            bl_a = v0_ff; bl_b = v1_ff; bl_w = wz_ff;
         end
      endcase
      bl_diff = 17'(bl_b) - 17'(bl_a);
      bl_prod = $signed({1'b0, bl_w}) * bl_diff;
      bl_sum  = 18'(bl_a) + bl_prod[33:16];
      bl_res  = bl_sum[15:0];
   end

   // Accumulate and per-octave updates
   logic [16:0]        amp_ff;
   logic signed [SW-1:0] sum_ff;
   logic signed [33:0] acc_p;
   logic [32:0]        amp_p;
   logic [44:0]        xl_p, zl_p;

   assign acc_p = $signed({1'b0, amp_ff}) * noise_ff;
   assign amp_p = amp_ff * persist_ff;
   assign xl_p  = x_ff * lacun_ff;
   assign zl_p  = z_ff * lacun_ff;

   // Final scaling and divider
   logic signed [P1W-1:0]  p1_ff;
   logic [16:0]            kf;
   logic [SP+16:0]         lo_ff;
   logic signed [HW+17:0]  hi_ff;
   logic signed [NW-1:0]   num;
   logic signed [DW-1:0]   nsh;
   logic [DW-1:0]          mag_ff;
   logic [16:0]            rem_ff, den_ff;
   logic                   neg_ff;
   logic [17:0]            r2;
   logic                   ge;
   logic signed [SW-15:0]  s16;

   assign s16 = sum_ff[SW-1:14];
   assign kf  = fvnh_pkg::ONE_Q16 - {1'b0, persist_ff};
   assign num = $signed({hi_ff, {SP{1'b0}}}) + $signed({{(NW-SP-17){1'b0}}, lo_ff});
   assign nsh = num[NW-1:17];
   assign r2  = {rem_ff, mag_ff[DW-1]};
   assign ge  = r2 >= {1'b0, den_ff};

   // Result
   logic signed [fvnh_pkg::H_W-1:0] qf, hval;
   logic [DW:0]                     qinc;
   logic                            rsp_valid_ff;
   fvnh_pkg::rsp_type               rsp_ff;
   fvnh_pkg::rsp_type               rsp_in;

   always_comb begin
      qinc = {1'b0, mag_ff} + {{DW{1'b0}}, (rem_ff != '0)};
      if (neg_ff)
         qf = -$signed({1'b0, qinc});
      else
         qf = $signed({2'b00, mag_ff});
      hval = qf + $signed({{(fvnh_pkg::H_W-17){1'b0}}, fvnh_pkg::HALF_Q16});
      priority if (hval < 0) begin
         rsp_in.height  = 16'h0000;
         rsp_in.clipped = 1'b1;
      end else if (hval > $signed(fvnh_pkg::H_W'(65535))) begin
         rsp_in.height  = 16'hFFFF;
         rsp_in.clipped = 1'b1;
      end else begin
         rsp_in.height  = hval[15:0];
         rsp_in.clipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         fvnh_pkg::CMD_LOAD: begin
            x_ff   <= req_data.x_coord;
            z_ff   <= req_data.z_coord;
            amp_ff <= fvnh_pkg::ONE_Q16;
            sum_ff <= '0;
         end
         fvnh_pkg::CMD_WGT: begin
            priority if (cmd.step == '0)
               g_ff <= x_ff[15:0];
            else if (cmd.step[0])
               t_ff <= cm_p[31:16];
            else if (cmd.step == fvnh_pkg::STEP_W'(4)) begin
               wx_ff <= cm_p[31:16];
               g_ff  <= z_ff[15:0];
            end else if (cmd.step == fvnh_pkg::STEP_W'(fvnh_pkg::WGT_LAST))
               wz_ff <= cm_p[31:16];
            else
               g_ff <= cm_p[31:16];
         end
         fvnh_pkg::CMD_LUT: begin
            unique case (cmd.step[2:0])
               3'd1: i_ff  <= fvnh_pkg::to_idx({8'h00, perm_rd_ff});
               3'd2: j_ff  <= fvnh_pkg::to_idx({8'h00, perm_rd_ff});
               3'd4: a0_ff <= level_rd_ff;
               3'd5: b0_ff <= level_rd_ff;
               3'd6: a1_ff <= level_rd_ff;
               3'd7: b1_ff <= level_rd_ff;
               default: ;
            endcase
         end
         fvnh_pkg::CMD_BLEND: begin
            unique case (cmd.step[1:0])
               2'd0:    v0_ff    <= bl_res;
               2'd1:    v1_ff    <= bl_res;
               default: noise_ff <= bl_res;
            endcase
         end
         fvnh_pkg::CMD_ACC: begin
            sum_ff <= sum_ff + {{(SW-34){acc_p[33]}}, acc_p};
            amp_ff <= amp_p[32:16];
            x_ff   <= xl_p[39:8];
            z_ff   <= zl_p[39:8];
         end
         fvnh_pkg::CMD_FIN: begin
            unique case (cmd.step[1:0])
               2'd0: p1_ff <= s16 * $signed({1'b0, fvnh_pkg::SQRT2_Q16});
               2'd1: begin
                  lo_ff <= p1_ff[SP-1:0] * kf;
                  hi_ff <= $signed(p1_ff[P1W-1:SP]) * $signed({1'b0, kf});
               end
               default: begin
                  neg_ff <= nsh[DW-1];
                  mag_ff <= nsh[DW-1] ? DW'(-nsh) : DW'(nsh);
                  rem_ff <= '0;
                  den_ff <= fvnh_pkg::ONE_Q16 - amp_ff;
               end
            endcase
         end
         fvnh_pkg::CMD_DIV: begin
            rem_ff <= ge ? 17'(r2 - {1'b0, den_ff}) : r2[16:0];
            mag_ff <= {mag_ff[DW-2:0], ge};
         end
         default: ;
      endcase
   end

   // Output register: frees the sequencer while a result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == fvnh_pkg::CMD_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == fvnh_pkg::CMD_OUT)
         rsp_ff <= rsp_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

/* rtl/fractal_value_noise_height.sv */
`timescale 1ns / 1ps
// Top level of the 2-D fractal value noise height generator.
// Joins fvnh_ctrl and fvnh_datapath; uses fvnh_pkg.
//
//   channel | direction | handshake            | beat carries
//   req     | in        | req_valid/req_ready  | fvnh_pkg::req_type (write or query)
//   rsp     | out       | rsp_valid/rsp_ready  | fvnh_pkg::rsp_type (height, clipped)
//   csr     | in        | csr_valid/csr_ready  | register index, 16-bit data
//
// A query runs, for each octave of the clamped octave count, the weights on the
// shared curve multiplier, the lookups on the single memory read ports, the
// blend unit and an accumulate; then the final scaling and a one-bit-per-cycle
// divider.
// Reset restores persistence, lacunarity and octave count; the tables keep
// their contents and must be loaded before any query.
// A finished result sits in the output register; the next beat is taken while
// it waits, and only a second result waits in the sequencer for the register.
module fractal_value_noise_height (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fvnh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fvnh_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   fvnh_pkg::cmd_type    cmd;
   fvnh_pkg::status_type status;

   // Config writes are always taken; software must write only when idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   fvnh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .status     (status),
      .cmd        (cmd)
   );

   fvnh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/fvnh_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the noise height block, bound to the top level.
// Uses fvnh_pkg.
module fvnh_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input fvnh_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fvnh_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [1:0]        csr_index,
   input logic [15:0]       csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_clip_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clipped |->
         (rsp_data.height == 16'h0000 || rsp_data.height == 16'hFFFF))
      else $error("clipped height not at a rail");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == fvnh_pkg::OP_QUERY
         |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after query");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port stalled");

endmodule

bind fractal_value_noise_height fvnh_checker u_fvnh_checker (.*);
